// ===== sv/scsa_pkg.sv =====
package scsa_pkg;

  localparam int unsigned NumPagesDef   = 64;
  localparam int unsigned NumClassesDef = 4;
  localparam int unsigned PageBytes     = 4096;
  localparam int unsigned HeaderBytesDef = 40;

  typedef enum logic [1:0] {
    KindAlloc = 2'd0,
    KindFree  = 2'd1,
    KindQuery = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadSize  = 3'd1,
    StNoPage   = 3'd2,
    StNotSlab  = 3'd3,
    StDblFree  = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] req_size;
    logic [17:0] obj_addr;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [17:0] granted_addr;
    logic [5:0]  slab_page;
    logic [6:0]  slot_index;
    logic        in_use_bit;
    logic [6:0]  pages_free;
  } rsp_t;

  // slab metadata word: class, recency rank, free slot count
  typedef struct packed {
    logic [1:0] cls;
    logic [7:0] rank;
    logic [6:0] free_slots;
  } meta_t;

  typedef enum logic [3:0] {
    SIdle,
    SSizeChk,
    SScanRd,
    SScanEval,
    SBmRd,
    SBmEval,
    SPageFind,
    SNewSlab,
    SLocRd,
    SLocEval,
    SLocBm,
    SRelRd,
    SRelEval,
    SOut
  } state_e;

  function automatic logic [8:0] class_bytes(input logic [1:0] c);
    logic [8:0] r;
    unique case (c)
      2'd0: r = 9'd32;
      2'd1: r = 9'd64;
      2'd2: r = 9'd128;
      default: r = 9'd256;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] class_shift(input logic [1:0] c);
    return 4'd5 + {2'd0, c};
  endfunction

endpackage

// ===== sv/scsa_stream_if.sv =====
interface scsa_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/scsa_meta_ram.sv =====
module scsa_meta_ram import scsa_pkg::*; #(
  parameter int unsigned NumPages = NumPagesDef,
  localparam int unsigned PgW = $clog2(NumPages)
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [PgW-1:0] waddr_i,
  input  meta_t          wdata_i,
  input  logic [PgW-1:0] raddr_i,
  output meta_t          rdata_o
);
  meta_t mem_q [NumPages];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/scsa_bitmap_ram.sv =====
module scsa_bitmap_ram #(
  parameter int unsigned Depth = 128,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);
  logic [63:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/size_class_slab_allocator_core.sv =====
// Slab allocator over NumPages one-page slabs, four size classes (32..256 bytes).
// One request at a time; one result per request. Metadata and slot bitmaps live in
// two memories with one registered read port each, so cost is set by the memory
// scan. An allocate of a valid size reads every page's metadata in turn, then the
// chosen slab's first bitmap word, and its second word when the first has no free
// slot. Opening a new slab instead picks the lowest free page and walks the metadata
// to bump the recency ranks of same-class slabs. A free that empties a slab rescans
// the metadata to fix ranks. The next request is taken only after the result beat
// has been accepted.
module size_class_slab_allocator_core import scsa_pkg::*; #(
  parameter int unsigned NumPages    = NumPagesDef,
  parameter int unsigned NumClasses  = NumClassesDef,
  parameter int unsigned HeaderBytes = HeaderBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  scsa_stream_if.sink   req_i,
  scsa_stream_if.source rsp_o
);
  localparam int unsigned PgW = $clog2(NumPages);
  localparam int unsigned CntW = $clog2(NumPages + 1);

  // objects per slab: object size plus one eighth of a byte of bitmap each
  localparam int unsigned SlotBits = (PageBytes - HeaderBytes) * 8;
  localparam int unsigned Raw0 = SlotBits / (32 * 8 + 1);
  localparam int unsigned Raw1 = SlotBits / (64 * 8 + 1);
  localparam int unsigned Raw2 = SlotBits / (128 * 8 + 1);
  localparam int unsigned Raw3 = SlotBits / (256 * 8 + 1);
  localparam logic [6:0] Slots0 = 7'((Raw0 == 0) ? 1 : (Raw0 > 127) ? 127 : Raw0);
  localparam logic [6:0] Slots1 = 7'((Raw1 == 0) ? 1 : (Raw1 > 127) ? 127 : Raw1);
  localparam logic [6:0] Slots2 = 7'((Raw2 == 0) ? 1 : (Raw2 > 127) ? 127 : Raw2);
  localparam logic [6:0] Slots3 = 7'((Raw3 == 0) ? 1 : (Raw3 > 127) ? 127 : Raw3);
  localparam logic [15:0] Span0 = 16'(32 * int'(Slots0));
  localparam logic [15:0] Span1 = 16'(64 * int'(Slots1));
  localparam logic [15:0] Span2 = 16'(128 * int'(Slots2));
  localparam logic [15:0] Span3 = 16'(256 * int'(Slots3));

  function automatic logic [6:0] slots_of(input logic [1:0] c);
    logic [6:0] r;
    unique case (c)
      2'd0: r = Slots0;
      2'd1: r = Slots1;
      2'd2: r = Slots2;
      default: r = Slots3;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] span_of(input logic [1:0] c);
    logic [15:0] r;
    unique case (c)
      2'd0: r = Span0;
      2'd1: r = Span1;
      2'd2: r = Span2;
      default: r = Span3;
    endcase
    return r;
  endfunction

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q;
  logic   rsp_valid_q;

  logic [NumPages-1:0] pfree_q, valid_q;
  logic [CntW-1:0]     nfree_q;
  logic [PgW:0]        scan_q;
  logic [1:0]          cls_q;
  logic                found_q;
  logic [PgW-1:0]      best_q;
  logic [7:0]          best_rank_q, rel_rank_q;
  meta_t               best_meta_q;
  logic                half_q;
  logic [6:0]          idx_q;
  logic [PgW-1:0]      page_q;

  // memory ports
  logic        m_we, b_we;
  logic [PgW-1:0] m_wa, m_ra;
  meta_t       m_wd, m_rd;
  logic [PgW:0] b_wa, b_ra;
  logic [63:0] b_wd, b_rd;

  scsa_meta_ram #(.NumPages(NumPages)) u_meta (
    .clk_i, .we_i(m_we), .waddr_i(m_wa), .wdata_i(m_wd), .raddr_i(m_ra), .rdata_o(m_rd));
  scsa_bitmap_ram #(.Depth(2*NumPages)) u_bm (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(b_wd), .raddr_i(b_ra), .rdata_o(b_rd));

  logic [PgW-1:0] scan_pg;
  assign scan_pg = scan_q[PgW-1:0];

  // address decode
  logic [17:0] a_page_full;
  logic [11:0] a_off;
  assign a_page_full = {12'd0, req_q.obj_addr[17:12]};
  assign a_off = req_q.obj_addr[11:0];

  // lowest clear bit of the bitmap word, limited to slot count
  logic [6:0] nslots;
  assign nslots = slots_of(cls_q);
  logic       lz_found;
  logic [5:0] lz_idx;
  always_comb begin
    lz_found = 1'b0;
    lz_idx = '0;
    for (int i = 63; i >= 0; i--) begin
      if (!b_rd[i] && ({half_q, 6'(i)} < nslots)) begin
        lz_found = 1'b1;
        lz_idx = 6'(i);
      end
    end
  end

  logic           pf_any;
  logic [PgW-1:0] pf_idx;
  always_comb begin
    pf_any = |pfree_q;
    pf_idx = '0;
    for (int i = NumPages-1; i >= 0; i--)
      if (pfree_q[i]) pf_idx = PgW'(i);
  end

  logic [15:0] loc_off;
  logic [6:0]  loc_idx;
  logic        loc_ok;
  always_comb begin
    loc_off = {4'd0, a_off} - 16'(HeaderBytes);
    loc_idx = 7'(loc_off >> class_shift(m_rd.cls));
    loc_ok = ({4'd0, a_off} >= 16'(HeaderBytes)) && (loc_off < span_of(m_rd.cls));
  end

  logic loc_hit;
  assign loc_hit = (a_page_full < 18'(NumPages)) && valid_q[page_q] && loc_ok;

  logic [17:0] grant_addr;
  assign grant_addr = 18'({12'd0, page_q} * PageBytes) + 18'(HeaderBytes) +
                      18'({11'd0, idx_q} << class_shift(cls_q));

  logic       size_bad;
  logic [1:0] size_cls;
  always_comb begin
    size_cls = 2'd3;
    if (req_q.req_size <= 16'd32) size_cls = 2'd0;
    else if (req_q.req_size <= 16'd64) size_cls = 2'd1;
    else if (req_q.req_size <= 16'd128) size_cls = 2'd2;
    size_bad = (req_q.req_size == 16'd0) || (req_q.req_size > 16'(class_bytes(2'(NumClasses-1))));
  end

  assign req_i.ready = (state_q == SIdle) && !rsp_valid_q;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  always_comb begin
    state_d = state_q;
    m_we = 1'b0; m_wa = scan_pg; m_wd = m_rd; m_ra = scan_pg;
    b_we = 1'b0; b_wa = {best_q, half_q}; b_wd = b_rd; b_ra = {best_q, half_q};
    unique case (state_q)
      SIdle:     if (req_i.valid && req_i.ready) state_d = SSizeChk;
      SSizeChk:  begin
        if (req_q.kind == KindAlloc) state_d = size_bad ? SOut : SScanRd;
        else if (req_q.kind == KindNone) state_d = SOut;
        else begin
          state_d = SLocRd;
          m_ra = a_page_full[PgW-1:0];
        end
      end
      SScanRd:   state_d = SScanEval;
      SScanEval: begin
        if (scan_q == (PgW+1)'(NumPages-1)) state_d = found_q ||
            (valid_q[scan_pg] && m_rd.cls == cls_q && m_rd.free_slots != 0 &&
             m_rd.rank < best_rank_q) ? SBmRd : SPageFind;
        else begin
          state_d = SScanRd;
          m_ra = PgW'(scan_q + 1'b1);
        end
        // the rank bump pass for a new slab follows in SNewSlab
      end
      SBmRd:     begin
        b_ra = {best_q, half_q};
        state_d = SBmEval;
      end
      SBmEval:   begin
        if (lz_found) begin
          b_we = 1'b1; b_wa = {best_q, half_q}; b_wd = b_rd | (64'd1 << lz_idx);
          m_we = 1'b1; m_wa = best_q;
          m_wd = best_meta_q; m_wd.free_slots = best_meta_q.free_slots - 7'd1;
          state_d = SOut;
        end else if (!half_q) begin
          b_ra = {best_q, 1'b1};
          state_d = SBmRd;
        end else state_d = SPageFind;
      end
      SPageFind: begin
        state_d = pf_any ? SNewSlab : SOut;
        m_ra = '0;
      end
      SNewSlab:  begin
        // walk all pages: bump rank of same-class slabs, then write the new slab
        if (valid_q[scan_pg] && m_rd.cls == cls_q && scan_pg != page_q) begin
          m_we = 1'b1; m_wa = scan_pg; m_wd = m_rd; m_wd.rank = m_rd.rank + 8'd1;
        end
        // clear the upper bitmap word of the new slab
        if (scan_q == '0) begin
          b_we = 1'b1; b_wa = {page_q, 1'b1}; b_wd = '0;
        end
        if (scan_q == (PgW+1)'(NumPages)) begin
          m_we = 1'b1; m_wa = page_q;
          m_wd.cls = cls_q; m_wd.rank = '0; m_wd.free_slots = nslots - 7'd1;
          b_we = 1'b1; b_wa = {page_q, 1'b0}; b_wd = 64'd1;
          state_d = SOut;
        end else m_ra = PgW'(scan_q + 1'b1);
      end
      SLocRd:    begin
        state_d = SLocEval;
        m_ra = page_q;
      end
      SLocEval:  begin
        state_d = loc_hit ? SLocBm : SOut;
        b_ra = {page_q, loc_idx[6]};
      end
      SLocBm:    begin
        if (req_q.kind == KindFree && b_rd[idx_q[5:0]]) begin
          b_we = 1'b1; b_wa = {page_q, idx_q[6]}; b_wd = b_rd & ~(64'd1 << idx_q[5:0]);
          m_we = 1'b1; m_wa = page_q; m_wd = best_meta_q;
          m_wd.free_slots = best_meta_q.free_slots + 7'd1;
          state_d = (best_meta_q.free_slots + 7'd1 >= nslots) ? SRelRd : SOut;
        end else state_d = SOut;
        m_ra = '0;
      end
      SRelRd:    state_d = SRelEval;
      SRelEval:  begin
        if (valid_q[scan_pg] && m_rd.cls == cls_q && m_rd.rank > rel_rank_q) begin
          m_we = 1'b1; m_wa = scan_pg; m_wd = m_rd; m_wd.rank = m_rd.rank - 8'd1;
        end
        if (scan_q == (PgW+1)'(NumPages-1)) state_d = SOut;
        else begin
          state_d = SRelRd;
          m_ra = PgW'(scan_q + 1'b1);
        end
      end
      SOut:      state_d = SIdle;
      default:   state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      rsp_valid_q <= 1'b0;
      pfree_q <= '1;
      valid_q <= '0;
      nfree_q <= CntW'(NumPages);
    end else begin
      state_q <= state_d;
      if (rsp_o.valid && rsp_o.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        SIdle: if (req_i.valid && req_i.ready) req_q <= req_i.data;
        SSizeChk: begin
          rsp_q <= '{status: (req_q.kind == KindAlloc && size_bad) ? StBadSize : StOk,
                     default: '0};
          cls_q <= size_cls;
          scan_q <= '0;
          found_q <= 1'b0;
          best_rank_q <= '1;
          half_q <= 1'b0;
          page_q <= a_page_full[PgW-1:0];
        end
        SScanEval: begin
          if (valid_q[scan_pg] && m_rd.cls == cls_q && m_rd.free_slots != 0 &&
              m_rd.rank < best_rank_q) begin
            found_q <= 1'b1; best_q <= scan_pg; best_rank_q <= m_rd.rank; best_meta_q <= m_rd;
          end
          scan_q <= scan_q + 1'b1;
        end
        SBmEval: begin
          if (lz_found) begin
            page_q <= best_q; idx_q <= {half_q, lz_idx};
            rsp_q.slab_page <= 6'(best_q); rsp_q.slot_index <= {half_q, lz_idx};
            rsp_q.in_use_bit <= 1'b1;
          end else half_q <= 1'b1;
        end
        SPageFind: begin
          scan_q <= '0;
          page_q <= pf_idx;
          if (!pf_any) rsp_q.status <= StNoPage;
        end
        SNewSlab: begin
          scan_q <= scan_q + 1'b1;
          if (scan_q == (PgW+1)'(NumPages)) begin
            pfree_q[page_q] <= 1'b0; valid_q[page_q] <= 1'b1; nfree_q <= nfree_q - 1'b1;
            idx_q <= '0;
            rsp_q.slab_page <= 6'(page_q); rsp_q.slot_index <= '0; rsp_q.in_use_bit <= 1'b1;
          end
        end
        SLocEval: begin
          cls_q <= m_rd.cls; best_meta_q <= m_rd; rel_rank_q <= m_rd.rank;
          idx_q <= loc_idx;
          if (loc_hit) begin
            rsp_q.slab_page <= 6'(page_q); rsp_q.slot_index <= loc_idx;
          end else rsp_q.status <= StNotSlab;
        end
        SLocBm: begin
          scan_q <= '0;
          if (req_q.kind == KindQuery) rsp_q.in_use_bit <= b_rd[idx_q[5:0]];
          else if (!b_rd[idx_q[5:0]]) rsp_q.status <= StDblFree;
          else if (best_meta_q.free_slots + 7'd1 >= nslots) begin
            valid_q[page_q] <= 1'b0; pfree_q[page_q] <= 1'b1; nfree_q <= nfree_q + 1'b1;
          end
        end
        SRelEval: scan_q <= scan_q + 1'b1;
        SOut: begin
          rsp_valid_q <= 1'b1;
          rsp_q.pages_free <= 7'(nfree_q);
          if (rsp_q.status == StOk && req_q.kind == KindAlloc) rsp_q.granted_addr <= grant_addr;
        end
        default: ;
      endcase
    end
  end

  a_rdy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !rsp_valid_q) else $error("ready while result pending");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(pfree_q) == int'(nfree_q)) else $error("free count mismatch");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pfree_q & valid_q) == '0) else $error("page both free and slab");
endmodule
